// ===== src/tes_pkg.sv =====
package tes_pkg;

   localparam logic [3:0] REQ_ENQUEUE    = 4'd0;
   localparam logic [3:0] REQ_POSTPONE   = 4'd1;
   localparam logic [3:0] REQ_CANCEL_DLY = 4'd2;
   localparam logic [3:0] REQ_ACTIVATE   = 4'd3;
   localparam logic [3:0] REQ_CANCEL_ACT = 4'd4;
   localparam logic [3:0] REQ_TRY        = 4'd5;
   localparam logic [3:0] REQ_FORCE      = 4'd6;
   localparam logic [3:0] REQ_SET_TIME   = 4'd7;
   localparam logic [3:0] REQ_ADVANCE    = 4'd8;

   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_NONE = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_EVENT = 2'd1;
   localparam logic [1:0] KIND_ACT   = 2'd2;
   localparam logic [1:0] KIND_DELAY = 2'd3;

   typedef struct packed {
      logic ld;
      logic sh;
   } cell_ctl_type;

   function automatic logic serial_older(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage

// ===== src/timed_event_scheduler_core.sv =====
// One item at a time: accept, decode, optional scan, then result register.
// Most requests go from decode straight to the result register; postpone,
// try/force from the postponed store and both cancels scan one cell per cycle
// first. A new request is not accepted until the result has been taken; the
// result register holds while rsp_stall is high.
// Reset (synchronous): counters, time, store counts and node ids cleared.
module timed_event_scheduler_core #(
   parameter int EVENT_DEPTH = 16,
   parameter int DELAY_DEPTH = 16,
   parameter int NODE_COUNT  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_type,
   input  logic [15:0] req_task_tag,
   input  logic [3:0]  req_node_id,
   input  logic [31:0] req_time_value,
   input  logic [31:0] req_cancel_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_served_kind,
   output logic [15:0] rsp_served_tag,
   output logic [3:0]  rsp_served_node,
   output logic [31:0] rsp_issued_id,
   output logic        rsp_wake
);
   import tes_pkg::*;

   localparam int EIW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam int ECW = $clog2(EVENT_DEPTH + 1);
   localparam int AIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int ACW = $clog2(NODE_COUNT + 1);
   localparam int DIW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int DCW = $clog2(DELAY_DEPTH + 1);
   localparam int SCW = (DCW > ACW) ? DCW : ACW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DEC  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  op_ff, op_in;
   logic [15:0] tag_ff, tag_in;
   logic [3:0]  node_ff, node_in;
   logic [31:0] tval_ff, tval_in;
   logic [31:0] cid_ff, cid_in;
   logic [31:0] ctr_ff, ctr_in;
   logic [31:0] now_ff, now_in;
   logic [ECW-1:0] ecnt_ff, ecnt_in;
   logic [ACW-1:0] acnt_ff, acnt_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [31:0] nsched_ff [NODE_COUNT];
   logic [31:0] nsched_in [NODE_COUNT];
   logic [SCW-1:0] i_ff, i_in;
   logic [DIW-1:0] best_ff, best_in;
   logic [31:0] bdue_ff, bdue_in;
   logic [31:0] bid_ff, bid_in;
   logic [1:0]  r_status_ff, r_status_in;
   logic [1:0]  r_kind_ff, r_kind_in;
   logic [15:0] r_tag_ff, r_tag_in;
   logic [3:0]  r_node_ff, r_node_in;
   logic [31:0] r_issued_ff, r_issued_in;
   logic        r_wake_ff, r_wake_in;

   logic [47:0] eq [EVENT_DEPTH];
   logic [3:0]  aq [NODE_COUNT];
   logic [79:0] dq [DELAY_DEPTH];
   cell_ctl_type e_ctl [EVENT_DEPTH];
   cell_ctl_type a_ctl [NODE_COUNT];
   cell_ctl_type d_ctl [DELAY_DEPTH];

   logic           e_push, e_pop, a_push, a_rm, d_push, d_rm;
   logic [AIW-1:0] a_k;
   logic [DIW-1:0] d_k;
   logic [47:0]    enew;
   logic [79:0]    dnew;
   logic [31:0]    nid;

   assign nid = (ctr_ff + 32'd1 == 32'd0) ? 32'd1 : ctr_ff + 32'd1;

   always_comb begin
      logic           fifos_empty;
      logic           node_ok;
      logic [AIW-1:0] nidx;
      logic [79:0]    dcell;
      logic [DIW-1:0] iidx;
      logic           take_act;
      fifos_empty = (ecnt_ff == '0) && (acnt_ff == '0);
      node_ok     = 32'(node_ff) < 32'(NODE_COUNT);
      nidx        = AIW'(node_ff);
      iidx        = i_ff[DIW-1:0];
      dcell       = dq[iidx];
      take_act    = 1'b0;
      state_in = state_ff;
      op_in = op_ff; tag_in = tag_ff; node_in = node_ff;
      tval_in = tval_ff; cid_in = cid_ff;
      ctr_in = ctr_ff; now_in = now_ff;
      ecnt_in = ecnt_ff; acnt_in = acnt_ff; dcnt_in = dcnt_ff;
      nsched_in = nsched_ff;
      i_in = i_ff; best_in = best_ff; bdue_in = bdue_ff; bid_in = bid_ff;
      r_status_in = r_status_ff; r_kind_in = r_kind_ff; r_tag_in = r_tag_ff;
      r_node_in = r_node_ff; r_issued_in = r_issued_ff; r_wake_in = r_wake_ff;
      e_push = 1'b0; e_pop = 1'b0; a_push = 1'b0; a_rm = 1'b0;
      d_push = 1'b0; d_rm = 1'b0; a_k = '0; d_k = '0;
      enew = {nid, tag_ff};
      dnew = {tval_ff, nid, tag_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_type; tag_in = req_task_tag; node_in = req_node_id;
               tval_in = req_time_value; cid_in = req_cancel_id;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            r_status_in = STAT_NONE; r_kind_in = KIND_NONE; r_tag_in = '0;
            r_node_in = '0; r_issued_in = '0; r_wake_in = 1'b0;
            state_in = ST_OUT;
            unique case (op_ff)
               REQ_ENQUEUE: begin
                  if (32'(ecnt_ff) >= 32'(EVENT_DEPTH)) begin
                     r_status_in = STAT_FULL;
                  end else begin
                     e_push = 1'b1; ctr_in = nid; ecnt_in = ecnt_ff + 1'b1;
                     r_status_in = STAT_DONE; r_wake_in = fifos_empty;
                  end
               end
               REQ_POSTPONE: begin
                  if (32'(dcnt_ff) >= 32'(DELAY_DEPTH)) begin
                     r_status_in = STAT_FULL;
                  end else if (dcnt_ff == '0) begin
                     d_push = 1'b1; ctr_in = nid; dcnt_in = dcnt_ff + 1'b1;
                     r_status_in = STAT_DONE; r_wake_in = 1'b1; r_issued_in = nid;
                  end else begin
                     best_in = '0; bdue_in = dq[0][79:48]; bid_in = dq[0][47:16];
                     i_in = SCW'(1); state_in = ST_SCAN;
                  end
               end
               REQ_CANCEL_DLY: begin
                  if (cid_ff != '0) begin
                     i_in = '0; state_in = ST_SCAN;
                  end
               end
               REQ_ACTIVATE: begin
                  if (node_ok && nsched_ff[nidx] == '0) begin
                     if (32'(acnt_ff) >= 32'(NODE_COUNT)) begin
                        r_status_in = STAT_FULL;
                     end else begin
                        a_push = 1'b1; ctr_in = nid; acnt_in = acnt_ff + 1'b1;
                        nsched_in[nidx] = nid;
                        r_status_in = STAT_DONE; r_issued_in = nid;
                        r_wake_in = fifos_empty;
                     end
                  end
               end
               REQ_CANCEL_ACT: begin
                  if (node_ok) begin
                     i_in = '0; state_in = ST_SCAN;
                  end
               end
               REQ_TRY, REQ_FORCE: begin
                  if (!fifos_empty) begin
                     if (ecnt_ff == '0) begin
                        take_act = 1'b1;
                     end else if (acnt_ff != '0) begin
                        take_act = serial_older(nsched_ff[AIW'(aq[0])], eq[0][47:16]);
                     end
                     if (take_act) begin
                        a_rm = 1'b1; a_k = '0; acnt_in = acnt_ff - 1'b1;
                        nsched_in[AIW'(aq[0])] = '0;
                        r_node_in = aq[0]; r_kind_in = KIND_ACT;
                     end else begin
                        e_pop = 1'b1; ecnt_in = ecnt_ff - 1'b1;
                        r_tag_in = eq[0][15:0]; r_kind_in = KIND_EVENT;
                     end
                     r_status_in = STAT_DONE;
                  end else if (dcnt_ff != '0) begin
                     best_in = '0; bdue_in = dq[0][79:48]; bid_in = dq[0][47:16];
                     i_in = SCW'(1); state_in = ST_SCAN;
                  end
               end
               REQ_SET_TIME: begin
                  now_in = tval_ff; r_status_in = STAT_DONE; r_wake_in = 1'b1;
               end
               REQ_ADVANCE: begin
                  now_in = now_ff + tval_ff; r_status_in = STAT_DONE; r_wake_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            unique case (op_ff)
               REQ_POSTPONE, REQ_TRY, REQ_FORCE: begin
                  if (32'(i_ff) < 32'(dcnt_ff)) begin
                     if (dcell[79:48] < bdue_ff || (dcell[79:48] == bdue_ff &&
                         serial_older(dcell[47:16], bid_ff))) begin
                        best_in = iidx; bdue_in = dcell[79:48]; bid_in = dcell[47:16];
                     end
                     i_in = i_ff + 1'b1;
                  end else begin
                     state_in = ST_OUT;
                     if (op_ff == REQ_POSTPONE) begin
                        d_push = 1'b1; ctr_in = nid; dcnt_in = dcnt_ff + 1'b1;
                        r_status_in = STAT_DONE; r_issued_in = nid;
                        r_wake_in = tval_ff < bdue_ff;
                     end else if (op_ff == REQ_FORCE || bdue_ff <= now_ff) begin
                        d_rm = 1'b1; d_k = best_ff; dcnt_in = dcnt_ff - 1'b1;
                        r_tag_in = dq[best_ff][15:0]; r_kind_in = KIND_DELAY;
                        r_status_in = STAT_DONE;
                     end
                  end
               end
               REQ_CANCEL_DLY: begin
                  if (32'(i_ff) < 32'(dcnt_ff)) begin
                     if (dcell[47:16] == cid_ff) begin
                        d_rm = 1'b1; d_k = iidx; dcnt_in = dcnt_ff - 1'b1;
                        r_status_in = STAT_DONE; state_in = ST_OUT;
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               REQ_CANCEL_ACT: begin
                  if (32'(i_ff) < 32'(acnt_ff)) begin
                     if (aq[i_ff[AIW-1:0]] == node_ff) begin
                        a_rm = 1'b1; a_k = i_ff[AIW-1:0]; acnt_in = acnt_ff - 1'b1;
                        r_status_in = STAT_DONE; nsched_in[nidx] = '0;
                        state_in = ST_OUT;
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end else begin
                     nsched_in[nidx] = '0; state_in = ST_OUT;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (d_rm) begin
         dnew = dq[DIW'(dcnt_ff - 1'b1)];
      end
   end

   genvar g;
   generate
      for (g = 0; g < EVENT_DEPTH; g++) begin : g_ev
         logic [47:0] nbr;
         if (g + 1 < EVENT_DEPTH) begin : g_n
            assign nbr = eq[g+1];
         end else begin : g_l
            assign nbr = '0;
         end
         assign e_ctl[g].ld = e_push && (ecnt_ff[EIW-1:0] == EIW'(g));
         assign e_ctl[g].sh = e_pop;
         tes_cell #(.W(48)) u_cell (
            .clock(clock), .ctl(e_ctl[g]), .new_d(enew), .nbr_d(nbr), .q(eq[g]));
      end
      for (g = 0; g < NODE_COUNT; g++) begin : g_act
         logic [3:0] nbr;
         if (g + 1 < NODE_COUNT) begin : g_n
            assign nbr = aq[g+1];
         end else begin : g_l
            assign nbr = '0;
         end
         assign a_ctl[g].ld = a_push && (acnt_ff[AIW-1:0] == AIW'(g));
         assign a_ctl[g].sh = a_rm && (AIW'(g) >= a_k);
         tes_cell #(.W(4)) u_cell (
            .clock(clock), .ctl(a_ctl[g]), .new_d(node_ff), .nbr_d(nbr), .q(aq[g]));
      end
      for (g = 0; g < DELAY_DEPTH; g++) begin : g_dly
         assign d_ctl[g].ld = (d_push && (dcnt_ff[DIW-1:0] == DIW'(g))) ||
                              (d_rm && (d_k == DIW'(g)));
         assign d_ctl[g].sh = 1'b0;
         tes_cell #(.W(80)) u_cell (
            .clock(clock), .ctl(d_ctl[g]), .new_d(dnew), .nbr_d(dq[g]), .q(dq[g]));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctr_ff   <= '0;
         now_ff   <= '0;
         ecnt_ff  <= '0;
         acnt_ff  <= '0;
         dcnt_ff  <= '0;
         for (int n = 0; n < NODE_COUNT; n++) begin
            nsched_ff[n] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         ctr_ff    <= ctr_in;
         now_ff    <= now_in;
         ecnt_ff   <= ecnt_in;
         acnt_ff   <= acnt_in;
         dcnt_ff   <= dcnt_in;
         nsched_ff <= nsched_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; tag_ff <= tag_in; node_ff <= node_in;
      tval_ff <= tval_in; cid_ff <= cid_in;
      i_ff <= i_in; best_ff <= best_in; bdue_ff <= bdue_in; bid_ff <= bid_in;
      r_status_ff <= r_status_in; r_kind_ff <= r_kind_in; r_tag_ff <= r_tag_in;
      r_node_ff <= r_node_in; r_issued_ff <= r_issued_in; r_wake_ff <= r_wake_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_status      = r_status_ff;
   assign rsp_served_kind = r_kind_ff;
   assign rsp_served_tag  = r_tag_ff;
   assign rsp_served_node = r_node_ff;
   assign rsp_issued_id   = r_issued_ff;
   assign rsp_wake        = r_wake_ff;

endmodule

// ===== src/tes_cell.sv =====
module tes_cell #(
   parameter int W = 8
) (
   input  logic                  clock,
   input  tes_pkg::cell_ctl_type ctl,
   input  logic [W-1:0]          new_d,
   input  logic [W-1:0]          nbr_d,
   output logic [W-1:0]          q
);
   import tes_pkg::*;

   logic [W-1:0] q_ff, q_in;

   always_comb begin
      q_in = q_ff;
      if (ctl.ld) begin
         q_in = new_d;
      end else if (ctl.sh) begin
         q_in = nbr_d;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ===== tb/timed_event_scheduler_checker.sv =====
`timescale 1ns / 1ps

module timed_event_scheduler_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [3:0]  req_type,
   input  logic [15:0] req_task_tag,
   input  logic [3:0]  req_node_id,
   input  logic [31:0] req_time_value,
   input  logic [31:0] req_cancel_id,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [1:0]  rsp_served_kind,
   input  logic [15:0] rsp_served_tag,
   input  logic [3:0]  rsp_served_node,
   input  logic [31:0] rsp_issued_id,
   input  logic        rsp_wake,
   output int          errors,
   output int          outstanding
);
   import tes_pkg::*;

   localparam int NODES = 16;
   localparam int EV_DEPTH = 16;
   localparam int DLY_DEPTH = 16;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  kind;
      logic [15:0] tag;
      logic [3:0]  node;
      logic [31:0] issued;
      logic        wake;
   } sched_result_type;

   sched_result_type expected_q[$];

   logic [31:0] id_ctr;
   logic [31:0] now;
   logic [31:0] ev_ids[$];
   logic [15:0] ev_tags[$];
   logic [3:0]  act_nodes[$];
   logic [31:0] node_sid[NODES];
   logic [31:0] dly_due[DLY_DEPTH];
   logic [31:0] dly_ids[DLY_DEPTH];
   logic [15:0] dly_tags[DLY_DEPTH];
   int          dly_n;

   function automatic logic is_older(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic int earliest_slot();
      int best;
      best = 0;
      for (int i = 1; i < dly_n; i++)
         if (dly_due[i] < dly_due[best] ||
             (dly_due[i] == dly_due[best] && is_older(dly_ids[i], dly_ids[best])))
            best = i;
      return best;
   endfunction

   task automatic take_id(output logic [31:0] id);
      id_ctr = id_ctr + 1;
      if (id_ctr == 0) id_ctr = 1;
      id = id_ctr;
   endtask

   task automatic drop_slot(input int k);
      dly_due[k] = dly_due[dly_n-1];
      dly_ids[k] = dly_ids[dly_n-1];
      dly_tags[k] = dly_tags[dly_n-1];
      dly_n--;
   endtask

   task automatic schedule(input logic [3:0] op, input logic [15:0] tag,
                           input logic [3:0] node, input logic [31:0] tv,
                           input logic [31:0] cid, output sched_result_type r);
      logic        empty;
      logic        pick_act;
      logic [31:0] id;
      int          k;
      r = '0;
      r.status = STAT_NONE;
      r.kind = KIND_NONE;
      empty = (ev_ids.size() == 0 && act_nodes.size() == 0);
      case (op)
         REQ_ENQUEUE: begin
            if (ev_ids.size() >= EV_DEPTH) r.status = STAT_FULL;
            else begin
               take_id(id);
               ev_ids = {ev_ids, id};
               ev_tags = {ev_tags, tag};
               r.status = STAT_DONE;
               r.wake = empty;
            end
         end
         REQ_POSTPONE: begin
            if (dly_n >= DLY_DEPTH) r.status = STAT_FULL;
            else begin
               if (dly_n == 0 || tv < dly_due[earliest_slot()]) r.wake = 1;
               take_id(id);
               r.issued = id;
               dly_due[dly_n] = tv;
               dly_ids[dly_n] = id;
               dly_tags[dly_n] = tag;
               dly_n++;
               r.status = STAT_DONE;
            end
         end
         REQ_CANCEL_DLY: begin
            if (cid != 0)
               for (int i = 0; i < dly_n; i++)
                  if (dly_ids[i] == cid) begin
                     drop_slot(i);
                     r.status = STAT_DONE;
                     break;
                  end
         end
         REQ_ACTIVATE: begin
            if (node_sid[node] == 0) begin
               if (act_nodes.size() >= NODES) r.status = STAT_FULL;
               else begin
                  take_id(id);
                  r.issued = id;
                  node_sid[node] = id;
                  act_nodes = {act_nodes, node};
                  r.status = STAT_DONE;
                  r.wake = empty;
               end
            end
         end
         REQ_CANCEL_ACT: begin
            for (int i = 0; i < act_nodes.size(); i++)
               if (act_nodes[i] == node) begin
                  act_nodes.delete(i);
                  r.status = STAT_DONE;
                  break;
               end
            node_sid[node] = 0;
         end
         REQ_TRY, REQ_FORCE: begin
            if (!empty) begin
               if (ev_ids.size() == 0) pick_act = 1;
               else if (act_nodes.size() == 0) pick_act = 0;
               else pick_act = is_older(node_sid[act_nodes[0]], ev_ids[0]);
               if (pick_act) begin
                  r.node = act_nodes[0];
                  act_nodes.delete(0);
                  node_sid[r.node] = 0;
                  r.kind = KIND_ACT;
               end else begin
                  r.tag = ev_tags[0];
                  ev_tags.delete(0);
                  ev_ids.delete(0);
                  r.kind = KIND_EVENT;
               end
               r.status = STAT_DONE;
            end else if (dly_n != 0) begin
               k = earliest_slot();
               if (op == REQ_FORCE || dly_due[k] <= now) begin
                  r.tag = dly_tags[k];
                  drop_slot(k);
                  r.kind = KIND_DELAY;
                  r.status = STAT_DONE;
               end
            end
         end
         REQ_SET_TIME: begin
            now = tv;
            r.status = STAT_DONE;
            r.wake = 1;
         end
         REQ_ADVANCE: begin
            now = now + tv;
            r.status = STAT_DONE;
            r.wake = 1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      sched_result_type r;
      sched_result_type e;
      if (reset) begin
         id_ctr = 0;
         now = 0;
         ev_ids.delete();
         ev_tags.delete();
         act_nodes.delete();
         for (int i = 0; i < NODES; i++) node_sid[i] = 0;
         dly_n = 0;
         expected_q.delete();
         errors <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result item");
               errors <= errors + 1;
            end else begin
               e = expected_q[0];
               expected_q.delete(0);
               if (e !== {rsp_status, rsp_served_kind, rsp_served_tag, rsp_served_node,
                          rsp_issued_id, rsp_wake}) begin
                  if (e.status !== rsp_status)
                     $error("status: expected %0d actual %0d", e.status, rsp_status);
                  if (e.kind !== rsp_served_kind)
                     $error("served_kind: expected %0d actual %0d", e.kind, rsp_served_kind);
                  if (e.tag !== rsp_served_tag)
                     $error("served_tag: expected %0h actual %0h", e.tag, rsp_served_tag);
                  if (e.node !== rsp_served_node)
                     $error("served_node: expected %0d actual %0d", e.node, rsp_served_node);
                  if (e.issued !== rsp_issued_id)
                     $error("issued_id: expected %0d actual %0d", e.issued, rsp_issued_id);
                  if (e.wake !== rsp_wake)
                     $error("wake: expected %0d actual %0d", e.wake, rsp_wake);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            schedule(req_type, req_task_tag, req_node_id, req_time_value, req_cancel_id, r);
            expected_q = {expected_q, r};
         end
         outstanding <= expected_q.size();
      end
   end

endmodule

// ===== tb/tb_timed_event_scheduler_core.sv =====
`timescale 1ns / 1ps

module tb_timed_event_scheduler_core;
   import tes_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [3:0]  req_type = '0;
   logic [15:0] req_task_tag = '0;
   logic [3:0]  req_node_id = '0;
   logic [31:0] req_time_value = '0;
   logic [31:0] req_cancel_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_served_kind;
   logic [15:0] rsp_served_tag;
   logic [3:0]  rsp_served_node;
   logic [31:0] rsp_issued_id;
   logic        rsp_wake;
   int          errors;
   int          outstanding;

   bit          quiet = 0;
   bit          hold_rsp = 0;
   int          idle_cycles = 0;
   int          sent = 0;
   logic [31:0] clock_guess = 0;

   always #5 clock = ~clock;

   timed_event_scheduler_core dut (.*);

   timed_event_scheduler_checker checker_i (.*);

   always @(posedge clock)
      rsp_stall <= hold_rsp || (!quiet && $urandom_range(99) < 12);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb_timed_event_scheduler_core failed");
         $finish;
      end
   end

   task automatic send(input logic [3:0] op, input logic [15:0] tag, input logic [3:0] node,
                       input logic [31:0] tv, input logic [31:0] cid);
      req_valid <= 1;
      req_type <= op;
      req_task_tag <= tag;
      req_node_id <= node;
      req_time_value <= tv;
      req_cancel_id <= cid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (op == REQ_SET_TIME) clock_guess = tv;
      if (op == REQ_ADVANCE) clock_guess = clock_guess + tv;
      if (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_random();
      int          pick;
      logic [31:0] tv;
      logic [31:0] cid;
      pick = $urandom_range(99);
      tv = ($urandom_range(9) == 0) ? $urandom : clock_guess + $urandom_range(120) - 40;
      cid = ($urandom_range(9) == 0) ? $urandom
            : ($urandom_range(9) == 0) ? 0 : $urandom_range(sent + 1, 1);
      if (pick < 15)
         send(REQ_ENQUEUE, 16'($urandom), 4'($urandom), $urandom, $urandom);
      else if (pick < 30)
         send(REQ_POSTPONE, 16'($urandom), 4'($urandom), tv, $urandom);
      else if (pick < 40)
         send(REQ_CANCEL_DLY, 16'($urandom), 4'($urandom), $urandom, cid);
      else if (pick < 55)
         send(REQ_ACTIVATE, 16'($urandom), 4'($urandom), $urandom, $urandom);
      else if (pick < 62)
         send(REQ_CANCEL_ACT, 16'($urandom), 4'($urandom), $urandom, $urandom);
      else if (pick < 82)
         send(REQ_TRY, 16'($urandom), 4'($urandom), $urandom, $urandom);
      else if (pick < 88)
         send(REQ_FORCE, 16'($urandom), 4'($urandom), $urandom, $urandom);
      else if (pick < 91)
         send(REQ_SET_TIME, 16'($urandom), 4'($urandom),
              ($urandom_range(4) == 0) ? $urandom : $urandom_range(1000), $urandom);
      else if (pick < 97)
         send(REQ_ADVANCE, 16'($urandom), 4'($urandom),
              ($urandom_range(19) == 0) ? $urandom : $urandom_range(50), $urandom);
      else
         send(4'($urandom_range(15, 9)), 16'($urandom), 4'($urandom), $urandom, $urandom);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty serves, extreme fields, unknown requests
      send(REQ_TRY, 16'h0000, 4'd0, 32'd0, 32'd0);
      send(REQ_FORCE, 16'hffff, 4'd15, 32'hffffffff, 32'hffffffff);
      send(REQ_CANCEL_DLY, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_CANCEL_ACT, 16'h0, 4'd15, 32'd0, 32'd0);
      send(4'd9, 16'hffff, 4'd15, 32'hffffffff, 32'hffffffff);
      send(4'd15, 16'h0, 4'd0, 32'd0, 32'd0);
      // equal due times, not yet due, advance wrap, then forced serves
      send(REQ_SET_TIME, 16'h0, 4'd0, 32'hfffffff0, 32'd0);
      send(REQ_POSTPONE, 16'hffff, 4'd0, 32'hffffffff, 32'd0);
      send(REQ_POSTPONE, 16'h1234, 4'd0, 32'hffffffff, 32'd0);
      send(REQ_POSTPONE, 16'h0001, 4'd0, 32'd0, 32'd0);
      send(REQ_TRY, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_CANCEL_DLY, 16'h0, 4'd0, 32'd0, 32'd3);
      send(REQ_ADVANCE, 16'h0, 4'd0, 32'h00000020, 32'd0);
      send(REQ_TRY, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_FORCE, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_FORCE, 16'h0, 4'd0, 32'd0, 32'd0);
      // mixed FIFO order, duplicate activation, cancel activation
      send(REQ_ACTIVATE, 16'h0, 4'd15, 32'd0, 32'd0);
      send(REQ_ENQUEUE, 16'habcd, 4'd0, 32'd0, 32'd0);
      send(REQ_ACTIVATE, 16'h0, 4'd15, 32'd0, 32'd0);
      send(REQ_ACTIVATE, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_CANCEL_ACT, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_TRY, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_TRY, 16'h0, 4'd0, 32'd0, 32'd0);
      send(REQ_SET_TIME, 16'h0, 4'd0, 32'd0, 32'd0);

      // fill every store past its depth
      for (int i = 0; i < 17; i++) send(REQ_ENQUEUE, 16'($urandom), 4'd0, 32'd0, 32'd0);
      for (int i = 0; i < 17; i++)
         send(REQ_POSTPONE, 16'($urandom), 4'd0, $urandom_range(30), 32'd0);
      for (int i = 0; i < 17; i++) send(REQ_ACTIVATE, 16'h0, 4'(i), 32'd0, 32'd0);
      for (int i = 0; i < 50; i++) send(REQ_FORCE, 16'h0, 4'd0, 32'd0, 32'd0);

      // receiver holds off while items keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 40; i++) send_random();
      join

      for (int i = 0; i < 1000; i++) begin
         quiet = (i >= 400 && i < 550);
         send_random();
      end
      quiet = 0;
      req_valid <= 0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("tb_timed_event_scheduler_core passed");
      else
         $display("tb_timed_event_scheduler_core failed");
      $finish;
   end

endmodule
